FILE: design/gtsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gtsg_pkg;

  localparam int NODE_W  = 6;
  localparam int ADDR_W  = 15;
  localparam int DEPTH   = 32768;
  localparam int OUT_W   = 48;
  localparam int ACC_W   = 62;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // configuration register indexes
  localparam logic [2:0] REG_NODES_X   = 3'd0;
  localparam logic [2:0] REG_NODES_Y   = 3'd1;
  localparam logic [2:0] REG_NODES_Z   = 3'd2;
  localparam logic [2:0] REG_INV_STEP  = 3'd3;
  localparam logic [2:0] REG_GRAD_FACT = 3'd4;

  // per-read accumulate control, carried down the read pipeline
  typedef struct packed {
    logic              vld;
    logic              to_val;
    logic signed [3:0] mx;
    logic signed [3:0] my;
    logic signed [3:0] mz;
  } rd_tag_t;

  function automatic logic [OUT_W-1:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd140737488355327;
    lo = -64'sd140737488355328;
    if (v > hi) begin
      sat48 = hi[OUT_W-1:0];
    end else if (v < lo) begin
      sat48 = lo[OUT_W-1:0];
    end else begin
      sat48 = v[OUT_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: design/grid_trilinear_sample_gradient.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel    Handshake              Payload
// input      start, busy            opcode, node_addr, field_value, pos_x/y/z, last
// result     result_valid (strobe)  value_out, grad_x/y/z, out_of_range, batch_end
// config     APB psel/penable/...   nodes_x/y/z, inv_step, grad_factor (4*i)
//
// A load transfer writes the node store in its accept cycle and leaves busy low.
// A sample holds busy through the three axis scalings, then per cell corner the
// coefficient multiplies, the node reads and a drain, then gradient scaling and
// the result strobe. The single shared 36x34 multiplier and the single-port
// node store set the length of a sample. Out-of-grid samples end after the axis
// scalings. rst clears control and config registers; the node store is not
// cleared. The result strobe lasts one cycle, no stall.
module grid_trilinear_sample_gradient #(
  parameter int MAX_SIDE   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input transfer
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode,
  input  wire logic [14:0] node_addr,
  input  wire logic signed [31:0] field_value,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] pos_z,
  input  wire logic        last,
  // result transfer
  output logic             result_valid,
  output logic signed [47:0] value_out,
  output logic signed [47:0] grad_x,
  output logic signed [47:0] grad_y,
  output logic signed [47:0] grad_z,
  output logic             out_of_range,
  output logic             batch_end,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SW = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
  localparam int NW = gtsg_pkg::NODE_W;

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AMUL  = 4'd1;
  localparam logic [3:0] S_APICK = 4'd2;
  localparam logic [3:0] S_COEF1 = 4'd3;
  localparam logic [3:0] S_COEF2 = 4'd4;
  localparam logic [3:0] S_READ  = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_GA    = 4'd7;
  localparam logic [3:0] S_GB    = 4'd8;
  localparam logic [3:0] S_GC    = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  // ---------------- config registers ----------------
  logic [NW-1:0] nodes_x, nodes_y, nodes_z;
  logic [31:0]   inv_step, grad_factor;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_x     <= NW'(32);
      nodes_y     <= NW'(32);
      nodes_z     <= NW'(32);
      inv_step    <= 32'd65536;
      grad_factor <= 32'd32768;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        gtsg_pkg::REG_NODES_X:   nodes_x     <= pwdata[NW-1:0];
        gtsg_pkg::REG_NODES_Y:   nodes_y     <= pwdata[NW-1:0];
        gtsg_pkg::REG_NODES_Z:   nodes_z     <= pwdata[NW-1:0];
        gtsg_pkg::REG_INV_STEP:  inv_step    <= pwdata;
        gtsg_pkg::REG_GRAD_FACT: grad_factor <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      gtsg_pkg::REG_NODES_X:   prdata = {{(32-NW){1'b0}}, nodes_x};
      gtsg_pkg::REG_NODES_Y:   prdata = {{(32-NW){1'b0}}, nodes_y};
      gtsg_pkg::REG_NODES_Z:   prdata = {{(32-NW){1'b0}}, nodes_z};
      gtsg_pkg::REG_INV_STEP:  prdata = inv_step;
      gtsg_pkg::REG_GRAD_FACT: prdata = grad_factor;
      default:                 prdata = 32'd0;
    endcase
  end

  function automatic logic [NW-1:0] clamp_n(input logic [NW-1:0] r);
    if (r < NW'(4)) begin
      clamp_n = NW'(4);
    end else if (int'(r) > MAX_SIDE) begin
      clamp_n = NW'(MAX_SIDE);
    end else begin
      clamp_n = r;
    end
  endfunction

  // ---------------- sequencer state ----------------
  logic [3:0]  state;
  logic [1:0]  ax;
  logic [2:0]  corner;
  logic [2:0]  rcnt;
  logic        dcnt;
  logic        accept, sample_go;

  logic [31:0]   posr   [3];
  logic [NW-1:0] nm1    [3];     // nodes - 1 per axis
  logic [NW-1:0] cellr  [3];
  logic [16:0]   w0r    [3];
  logic [16:0]   w1r    [3];
  logic [NW-1:0] n0r;
  logic [2*NW-1:0] n01r;
  logic          oor, lastr;
  logic [24:0]   coef;

  logic signed [gtsg_pkg::ACC_W-1:0] acc_v, acc_x, acc_y, acc_z;
  logic signed [35:0] s16;
  logic signed [52:0] ph;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign sample_go = accept && opcode;
  assign result_valid = (state == S_DONE);

  // ---------------- shared multiplier ----------------
  logic signed [35:0] ma;
  logic signed [33:0] mb;
  logic signed [69:0] mreg;
  logic [SW-1:0]      rdata;
  logic signed [gtsg_pkg::ACC_W-1:0] g_sel;

  always_comb begin
    unique case (ax)
      2'd0:    g_sel = acc_x;
      2'd1:    g_sel = acc_y;
      default: g_sel = acc_z;
    endcase
  end

  // round half up to Q16.16 from the Q.24 sum
  assign s16 = 36'((g_sel + signed'(gtsg_pkg::ACC_W'(24'h800000))) >>> 24);

  always_comb begin
    unique case (state)
      S_AMUL: begin
        ma = {4'd0, posr[ax]};
        mb = {2'd0, inv_step};
      end
      S_COEF1: begin
        ma = {19'd0, (corner[2] ? w1r[0] : w0r[0])};
        mb = {17'd0, (corner[1] ? w1r[1] : w0r[1])};
      end
      S_COEF2: begin
        ma = {19'd0, (corner[0] ? w1r[2] : w0r[2])};
        mb = mreg[33:0];
      end
      S_GA: begin
        ma = s16;
        mb = {18'd0, grad_factor[31:16]};
      end
      S_GB: begin
        ma = s16;
        mb = {18'd0, grad_factor[15:0]};
      end
      default: begin
        ma = 36'(signed'(rdata));
        mb = {9'd0, coef};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mreg <= 70'(ma) * 70'(mb);
  end

  // ---------------- node store ----------------
  logic [gtsg_pkg::ADDR_W-1:0] rd_addr, ram_addr;
  logic                        ram_we;

  assign ram_we   = accept && !opcode;
  assign ram_addr = busy ? rd_addr : node_addr;

  gtsg_ram #(
    .WIDTH (SW),
    .DEPTH (gtsg_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (field_value[SW-1:0]),
    .rdata (rdata)
  );

  // ---------------- read issue: address and stencil weights ----------------
  logic [NW-1:0] cc [3];
  logic [NW-1:0] qq [3];
  logic signed [3:0] mm [3];
  logic [1:0]  r_ax;
  logic        r_j;
  logic [2:0]  rm1;
  gtsg_pkg::rd_tag_t tag0, tag1, tag2;

  assign rm1  = rcnt - 3'd1;
  assign r_ax = rm1[2:1];
  assign r_j  = rm1[0];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cc[a] = cellr[a] + NW'(corner[2-a]);
      qq[a] = cc[a];
      mm[a] = 4'sd0;
      if (rcnt == 3'd0) begin
        // center node: value term, and the center part of one-sided stencils
        if (cc[a] == '0) begin
          mm[a] = -4'sd3;
        end else if (cc[a] == nm1[a]) begin
          mm[a] = 4'sd3;
        end
      end else if (r_ax == 2'(a)) begin
        if (cc[a] == '0) begin
          qq[a] = cc[a] + (r_j ? NW'(2) : NW'(1));
          mm[a] = r_j ? -4'sd1 : 4'sd4;
        end else if (cc[a] == nm1[a]) begin
          qq[a] = cc[a] - (r_j ? NW'(2) : NW'(1));
          mm[a] = r_j ? 4'sd1 : -4'sd4;
        end else begin
          qq[a] = r_j ? cc[a] - NW'(1) : cc[a] + NW'(1);
          mm[a] = r_j ? -4'sd1 : 4'sd1;
        end
      end
    end
    rd_addr = gtsg_pkg::ADDR_W'(19'(qq[0]) + 19'(qq[1]) * 19'(n0r)
                                + 19'(qq[2]) * 19'(n01r));
    tag0.vld    = (state == S_READ);
    tag0.to_val = (rcnt == 3'd0);
    tag0.mx     = mm[0];
    tag0.my     = mm[1];
    tag0.mz     = mm[2];
  end

  function automatic logic signed [gtsg_pkg::ACC_W-1:0] scale_small(
    input logic signed [gtsg_pkg::ACC_W-1:0] p,
    input logic signed [3:0] m
  );
    logic signed [gtsg_pkg::ACC_W-1:0] r;
    unique case (m < 0 ? -m : m)
      4'sd1:   r = p;
      4'sd3:   r = p + (p <<< 1);
      4'sd4:   r = p <<< 2;
      default: r = '0;
    endcase
    scale_small = (m < 0) ? -r : r;
  endfunction

  logic signed [gtsg_pkg::ACC_W-1:0] prod;
  assign prod = mreg[gtsg_pkg::ACC_W-1:0];

  // ---------------- axis pick ----------------
  logic [31:0]   ip;
  logic [15:0]   dp;
  logic          top, over;
  logic [NW-1:0] nax;

  assign ip   = mreg[63:32];
  assign dp   = mreg[31:16];
  assign nax  = nm1[ax];
  assign top  = (ip == {{(32-NW){1'b0}}, nax});
  assign over = (ip > {{(32-NW){1'b0}}, nax}) || (top && dp != 16'd0);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ax    <= '0;
      corner <= '0;
      rcnt  <= '0;
      dcnt  <= 1'b0;
      tag1  <= '0;
      tag2  <= '0;
    end else begin
      tag1 <= tag0;
      tag2 <= tag1;
      unique case (state)
        S_IDLE: begin
          if (sample_go) begin
            state <= S_AMUL;
            ax    <= '0;
          end
        end
        S_AMUL: state <= S_APICK;
        S_APICK: begin
          if (ax == 2'd2) begin
            state  <= (oor || over) ? S_DONE : S_COEF1;
            corner <= '0;
            ax     <= '0;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_AMUL;
          end
        end
        S_COEF1: state <= S_COEF2;
        S_COEF2: begin
          state <= S_READ;
          rcnt  <= '0;
        end
        S_READ: begin
          if (rcnt == 3'd6) begin
            state <= S_DRAIN;
            dcnt  <= 1'b0;
          end else begin
            rcnt <= rcnt + 3'd1;
          end
        end
        S_DRAIN: begin
          dcnt <= 1'b1;
          if (dcnt) begin
            if (corner == 3'd7) begin
              state <= S_GA;
              ax    <= '0;
            end else begin
              corner <= corner + 3'd1;
              state  <= S_COEF1;
            end
          end
        end
        S_GA: state <= S_GB;
        S_GB: state <= S_GC;
        S_GC: begin
          if (ax == 2'd2) begin
            state <= S_DONE;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_GA;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  logic signed [63:0] gsum;
  assign gsum = 64'(ph) + 64'((signed'(mreg[52:0]) + 53'sh8000) >>> 16);

  always_ff @(posedge clk) begin
    if (sample_go) begin
      posr[0] <= pos_x;
      posr[1] <= pos_y;
      posr[2] <= pos_z;
      nm1[0]  <= clamp_n(nodes_x) - NW'(1);
      nm1[1]  <= clamp_n(nodes_y) - NW'(1);
      nm1[2]  <= clamp_n(nodes_z) - NW'(1);
      n0r     <= clamp_n(nodes_x);
      n01r    <= (2*NW)'(clamp_n(nodes_x)) * (2*NW)'(clamp_n(nodes_y));
      lastr   <= last;
      oor     <= 1'b0;
      acc_v   <= '0;
      acc_x   <= '0;
      acc_y   <= '0;
      acc_z   <= '0;
    end
    if (state == S_APICK) begin
      oor       <= oor || over;
      cellr[ax] <= top ? nax - NW'(1) : ip[NW-1:0];
      w1r[ax]   <= top ? gtsg_pkg::ONE_Q16 : {1'b0, dp};
      w0r[ax]   <= top ? 17'd0 : gtsg_pkg::ONE_Q16 - {1'b0, dp};
      if (ax == 2'd2 && (oor || over)) begin
        value_out <= '0;
        grad_x    <= '0;
        grad_y    <= '0;
        grad_z    <= '0;
        out_of_range <= 1'b1;
        batch_end <= lastr;
      end
    end
    if (state == S_READ && rcnt == 3'd0) begin
      coef <= 25'((mreg[50:0] + 51'h800000) >> 24);
    end
    if (tag2.vld) begin
      if (tag2.to_val) begin
        acc_v <= acc_v + prod;
      end
      acc_x <= acc_x + scale_small(prod, tag2.mx);
      acc_y <= acc_y + scale_small(prod, tag2.my);
      acc_z <= acc_z + scale_small(prod, tag2.mz);
    end
    if (state == S_GA && ax == 2'd0) begin
      value_out    <= gtsg_pkg::sat48(
                        64'((acc_v + signed'(gtsg_pkg::ACC_W'(24'h800000))) >>> 24));
      out_of_range <= 1'b0;
      batch_end    <= lastr;
    end
    if (state == S_GB) begin
      ph <= mreg[52:0];
    end
    if (state == S_GC) begin
      unique case (ax)
        2'd0:    grad_x <= gtsg_pkg::sat48(gsum);
        2'd1:    grad_y <= gtsg_pkg::sat48(gsum);
        default: grad_z <= gtsg_pkg::sat48(gsum);
      endcase
    end
  end

`ifndef SYNTHESIS
  // result strobe is a single cycle
  a_strobe_one: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result strobe longer than one cycle");

  // an out-of-grid result carries zero payload
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && out_of_range) |->
      (value_out == 0 && grad_x == 0 && grad_y == 0 && grad_z == 0))
    else $error("out-of-grid result with nonzero payload");

  // accumulate stage only runs while node reads are in flight
  a_acc_window: assert property (@(posedge clk) disable iff (rst)
    tag2.vld |-> (state == S_READ || state == S_DRAIN))
    else $error("accumulate outside read window");

  // no store write while a sample is at work
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !ram_we) else $error("store write while busy");
`endif

endmodule
`default_nettype wire

FILE: design/gtsg_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gtsg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire
